// ===== src/brc_pkg.sv =====
package brc_pkg;

	// largest block the buffer holds
	localparam int unsigned BLOCK_MAX = 64;
	localparam int unsigned BUF_W     = BLOCK_MAX;
	localparam int unsigned IDX_W     = $clog2(BLOCK_MAX);
	localparam int unsigned CNT_W     = $clog2(BLOCK_MAX + 1);

	// configuration port
	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 7;

	localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_BITS  = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_DECODE_MODE = CFG_ADDR_W'(1);

	localparam logic [CFG_DATA_W-1:0] BLOCK_BITS_RST = CFG_DATA_W'(4);

	// effective block size: zero counts as one, large values saturate
	function automatic logic [CNT_W-1:0] blk_size(input logic [CFG_DATA_W-1:0] bits);
		logic [CNT_W-1:0] res;
		if (bits == '0) begin
			res = CNT_W'(1);
		end else if (32'(bits) > BLOCK_MAX) begin
			res = CNT_W'(BLOCK_MAX);
		end else begin
			res = CNT_W'(bits);
		end
		return res;
	endfunction

endpackage

// ===== src/bit_block_rotate_codec_top.sv =====
// Byte stream block rotator. Each accepted word on the slave side is taken
// apart one bit per cycle, MSB first, into a block buffer; when the block
// reaches the configured size (or the word marked tlast ends) the block is
// read back one bit per cycle, unless a full output register stalls it,
// through a single bit select, rotated right by one in encode mode and left
// by one in decode mode, and the bits are packed into bytes on the master
// side. A new word is not accepted until the last one is shifted in and any
// block it closed is flushed. The block size and mode are written through
// cfg_we/cfg_addr/cfg_wdata (index 0 block size, index 1 decode mode); the
// user must write them only while the block is idle; the block does not enforce it.
module bit_block_rotate_codec_top
	import brc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // [7:0] in_byte
	input  logic                  s_tlast,  // in_last
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,  // [7:0] out_byte
	output logic                  m_tlast   // out_last
);

	typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_EMIT} state_t;

	state_t            state_q;
	logic [CFG_DATA_W-1:0] block_bits_q;
	logic              decode_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic [3:0]        rem_q;
	logic [BUF_W-1:0]  buf_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  blk_n_q;
	logic [CNT_W-1:0]  k_q;
	logic [7:0]        asm_q;
	logic [2:0]        out_fill_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;
	logic              m_tlast_q;

	logic [CNT_W-1:0]  size;
	logic [CNT_W-1:0]  fill_inc;
	logic              flush_now;
	logic [CNT_W-1:0]  pos;
	logic [CNT_W-1:0]  n_m1;
	logic [IDX_W-1:0]  src;
	logic              emit_bit;
	logic              byte_full;
	logic              can_push;
	logic              stall;
	logic              final_emit;
	logic              push_last;
	logic              word_out;

	// shift side
	assign size      = blk_size(block_bits_q);
	assign fill_inc  = fill_q + CNT_W'(1);
	assign flush_now = (fill_inc >= size) || (last_q && (rem_q == 4'd1));

	// rotated bit select: the one shared unit of the flush
	assign pos  = k_q - CNT_W'(1);
	assign n_m1 = blk_n_q - CNT_W'(1);
	always_comb begin
		if (decode_q) begin
			src = (pos == '0) ? n_m1[IDX_W-1:0] : pos[IDX_W-1:0] - IDX_W'(1);
		end else begin
			src = (pos == n_m1) ? '0 : pos[IDX_W-1:0] + IDX_W'(1);
		end
	end
	assign emit_bit = buf_q[src];

	// output handoff
	assign byte_full  = (out_fill_q == 3'd7);
	assign can_push   = !m_tvalid_q || m_tready;
	assign stall      = byte_full && !can_push;
	assign final_emit = (k_q == CNT_W'(1));
	assign push_last  = last_q && (rem_q == 4'd0) && final_emit;
	// a completed byte loads the output register this cycle
	assign word_out   = (state_q == ST_EMIT) && byte_full && !stall;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// sequencer, datapath and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			block_bits_q <= BLOCK_BITS_RST;
			decode_q     <= 1'b0;
			byte_q       <= '0;
			last_q       <= 1'b0;
			rem_q        <= '0;
			buf_q        <= '0;
			fill_q       <= '0;
			blk_n_q      <= '0;
			k_q          <= '0;
			asm_q        <= '0;
			out_fill_q   <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tlast_q    <= 1'b0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				if (cfg_addr == REG_BLOCK_BITS) begin
					block_bits_q <= cfg_wdata;
				end else if (cfg_addr == REG_DECODE_MODE) begin
					decode_q <= cfg_wdata[0];
				end
			end

			// master side drains
			if (m_tvalid_q && m_tready && !word_out) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						byte_q  <= s_tdata;
						last_q  <= s_tlast;
						rem_q   <= 4'd8;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					buf_q  <= {buf_q[BUF_W-2:0], byte_q[7]};
					byte_q <= {byte_q[6:0], 1'b0};
					rem_q  <= rem_q - 4'd1;
					fill_q <= fill_inc;
					if (flush_now) begin
						blk_n_q <= fill_inc;
						k_q     <= fill_inc;
						state_q <= ST_EMIT;
					end else if (rem_q == 4'd1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!stall) begin
						asm_q      <= {asm_q[6:0], emit_bit};
						out_fill_q <= out_fill_q + 3'd1;
						k_q        <= k_q - CNT_W'(1);
						if (byte_full) begin
							m_tvalid_q <= 1'b1;
							m_tdata_q  <= {asm_q[6:0], emit_bit};
							m_tlast_q  <= push_last;
						end
						if (final_emit) begin
							buf_q   <= '0;
							fill_q  <= '0;
							state_q <= (rem_q == 4'd0) ? ST_IDLE : ST_SHIFT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// block never holds more bits than the buffer
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= BLOCK_MAX)
		else $error("block fill beyond buffer");

	// flush counter stays inside the block being flushed
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (k_q != '0) && (k_q <= blk_n_q))
		else $error("flush index out of block");

	// the final word of a message leaves nothing behind
	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && !stall && byte_full && push_last
		|=> (out_fill_q == '0) && (fill_q == '0) && (state_q == ST_IDLE))
		else $error("state left over after last word");

	// an accepted word starts a full eight bit shift
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> (state_q == ST_SHIFT) && (rem_q == 4'd8))
		else $error("accept did not start shift");
`endif

endmodule

// ===== tb/sv/bit_block_rotate_codec_top_tb.sv =====
module bit_block_rotate_codec_top_tb;
	import brc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// indexes past the two registers, which the block ignores
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = CFG_ADDR_W'(2);
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = CFG_ADDR_W'(3);

	localparam int SETTLE_CYCLES = 200;
	localparam longint CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} coded_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;  // [7:0] in_byte
	logic                  s_tlast;  // in_last
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;  // [7:0] out_byte
	logic                  m_tlast;  // out_last

	// predicted coder state and registers
	logic [CFG_DATA_W-1:0] blk_bits_reg;
	logic                  decode_reg;
	logic [63:0]           blk_buf;
	int                    blk_fill;
	logic [7:0]            asm_byte;
	int                    asm_fill;

	coded_word_t coded_q[$];
	int          err_count = 0;
	int          words_sent;
	bit          calm;
	longint      cycles = 0;

	bit_block_rotate_codec_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_err(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// block size as the coder sees it: zero is one, large values saturate
	function automatic int eff_block_size();
		if (blk_bits_reg == '0) begin
			return 1;
		end
		if (int'(blk_bits_reg) > int'(BLOCK_MAX)) begin
			return int'(BLOCK_MAX);
		end
		return int'(blk_bits_reg);
	endfunction

	// shift one coded bit into the output byte, msb first
	function automatic void pack_bit(input logic b);
		coded_word_t w;
		asm_byte = {asm_byte[6:0], b};
		if (asm_fill >= 7) begin
			w.data = asm_byte;
			w.last = 1'b0;
			coded_q.insert(coded_q.size(), w);
			asm_byte = '0;
			asm_fill = 0;
		end else begin
			asm_fill++;
		end
	endfunction

	// rotate the open block by one bit and send its bits out
	function automatic void rotate_block();
		int          n;
		logic [63:0] mask;
		logic [63:0] rot;
		n = blk_fill;
		if (n == 0) begin
			return;
		end
		mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
		if (decode_reg) begin
			rot = ((blk_buf << 1) & mask) | ((blk_buf >> (n - 1)) & 64'd1);
		end else begin
			rot = (blk_buf >> 1) | ((blk_buf & 64'd1) << (n - 1));
		end
		rot &= mask;
		for (int k = n; k > 0; k--) begin
			pack_bit(rot[k-1]);
		end
		blk_buf = '0;
		blk_fill = 0;
	endfunction

	// expected output words for one accepted input word
	function automatic void code_byte(input logic [7:0] b, input logic last);
		int          q0;
		coded_word_t w;
		q0 = coded_q.size();
		for (int i = 7; i >= 0; i--) begin
			blk_buf = {blk_buf[62:0], b[i]};
			blk_fill++;
			if (blk_fill >= eff_block_size() || (last && i == 0)) begin
				rotate_block();
			end
		end
		if (last) begin
			if (coded_q.size() > q0) begin
				w = coded_q.pop_back();
				w.last = 1'b1;
				coded_q.insert(coded_q.size(), w);
			end
			blk_buf = '0;
			blk_fill = 0;
			asm_byte = '0;
			asm_fill = 0;
		end
	endfunction

	// master side: check each word, stall at random
	always @(posedge clk) begin
		coded_word_t want;
		if (m_tvalid && m_tready) begin
			if (coded_q.size() == 0) begin
				report_err($sformatf("unexpected word %02h last %b", m_tdata, m_tlast));
			end else begin
				want = coded_q.pop_front();
				if (m_tdata !== want.data) begin
					report_err($sformatf("data %02h, want %02h", m_tdata, want.data));
				end
				if (m_tlast !== want.last) begin
					report_err($sformatf("last %b, want %b (data %02h)",
						m_tlast, want.last, want.data));
				end
			end
		end
		m_tready <= calm || ($urandom_range(0, 99) >= 7);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL bit_block_rotate_codec_top");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		while (!calm && $urandom_range(0, 99) < 7) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		code_byte(b, last);
		words_sent++;
	endtask

	task automatic send_random(input int len, input logic close);
		for (int i = 0; i < len; i++) begin
			send_word(8'($urandom_range(0, 255)), close && (i == len - 1));
		end
	endtask

	// drop valid, drain all expected words, let the shifter finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (coded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BLOCK_BITS: begin
				blk_bits_reg = val;
			end
			REG_DECODE_MODE: begin
				decode_reg = val[0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	task automatic random_config();
		int pick;
		logic [CFG_DATA_W-1:0] bits;
		pick = $urandom_range(0, 9);
		case (pick)
			0: bits = '0;
			1: bits = CFG_DATA_W'($urandom_range(65, 127));
			2: bits = CFG_DATA_W'(BLOCK_MAX);
			3: bits = CFG_DATA_W'(1);
			default: bits = CFG_DATA_W'($urandom_range(1, 64));
		endcase
		write_reg(REG_BLOCK_BITS, bits);
		write_reg(REG_DECODE_MODE, CFG_DATA_W'($urandom_range(0, 127)));
		if ($urandom_range(0, 4) == 0) begin
			write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
				CFG_DATA_W'($urandom_range(0, 127)));
		end
	endtask

	// reset values: block of four, encode
	task automatic test_reset_defaults();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h5A, 1'b0);
		send_word(8'hC3, 1'b1);
		settle();
	endtask

	// block size zero acts as one: a single-byte message in decode mode, then a two-byte one in encode mode
	task automatic test_block_size_zero();
		write_reg(REG_BLOCK_BITS, '0);
		write_reg(REG_DECODE_MODE, CFG_DATA_W'(1));
		send_word(8'hB7, 1'b1);
		settle();
		write_reg(REG_DECODE_MODE, '0);
		send_word(8'h81, 1'b0);
		send_word(8'h7E, 1'b1);
		settle();
	endtask

	// full-size block, saturated size, one-bit and byte-sized blocks
	task automatic test_block_size_extremes();
		write_reg(REG_BLOCK_BITS, CFG_DATA_W'(BLOCK_MAX));
		send_word(8'h80, 1'b0);
		for (int i = 0; i < 7; i++) begin
			send_word(8'h00, 1'b0);
		end
		send_word(8'h01, 1'b1);
		settle();
		write_reg(REG_BLOCK_BITS, '1);
		write_reg(REG_DECODE_MODE, CFG_DATA_W'(1));
		send_word(8'h80, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h01, 1'b1);
		settle();
		write_reg(REG_BLOCK_BITS, CFG_DATA_W'(1));
		send_word(8'hA5, 1'b1);
		settle();
		write_reg(REG_BLOCK_BITS, CFG_DATA_W'(8));
		send_word(8'h96, 1'b1);
		settle();
	endtask

	// shrink the block while one is open: it closes on its next bit
	task automatic test_size_change_mid_message();
		write_reg(REG_BLOCK_BITS, CFG_DATA_W'(13));
		write_reg(REG_DECODE_MODE, '0);
		send_word(8'hE3, 1'b0);
		send_word(8'h3C, 1'b0);
		settle();
		write_reg(REG_BLOCK_BITS, CFG_DATA_W'(2));
		send_word(8'hD2, 1'b1);
		settle();
	endtask

	// writes past the register file change nothing
	task automatic test_unused_index();
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 127)));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 127)));
		send_word(8'h4B, 1'b1);
		settle();
	endtask

	// random messages under random settings, sometimes resized mid-message
	task automatic test_random_messages(input int n_words);
		int stop_at;
		int len;
		int cut;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			random_config();
			repeat ($urandom_range(1, 4)) begin
				len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
				if (len >= 2 && $urandom_range(0, 5) == 0) begin
					cut = $urandom_range(1, len - 1);
					send_random(cut, 1'b0);
					settle();
					write_reg(REG_BLOCK_BITS, CFG_DATA_W'($urandom_range(0, 127)));
					send_random(len - cut, 1'b1);
				end else begin
					send_random(len, 1'b1);
				end
			end
			settle();
		end
	endtask

	// long stretch with no idling on either side
	task automatic test_calm_stream();
		calm = 1'b1;
		write_reg(REG_BLOCK_BITS, CFG_DATA_W'($urandom_range(1, 24)));
		write_reg(REG_DECODE_MODE, CFG_DATA_W'($urandom_range(0, 1)));
		for (int m = 0; m < 6; m++) begin
			send_random($urandom_range(6, 14), 1'b1);
		end
		settle();
		calm = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_addr  = '0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		calm      = 1'b0;
		words_sent = 0;
		blk_bits_reg = BLOCK_BITS_RST;
		decode_reg   = 1'b0;
		blk_buf      = '0;
		blk_fill     = 0;
		asm_byte     = '0;
		asm_fill     = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_block_size_zero();
		test_block_size_extremes();
		test_size_change_mid_message();
		test_unused_index();
		test_random_messages(280);
		test_calm_stream();
		test_random_messages(40);

		settle();
		if (err_count == 0) begin
			$display("PASS bit_block_rotate_codec_top");
		end else begin
			$display("FAIL bit_block_rotate_codec_top");
		end
		$finish;
	end

endmodule
